/* hw/rtl/systematic_resample_index_assert.svh */
// Assertion macros used by the checker file of the systematic resampler.
`ifndef SYSTEMATIC_RESAMPLE_INDEX_ASSERT_SVH
`define SYSTEMATIC_RESAMPLE_INDEX_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("systematic_resample_index assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SRI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("systematic_resample_index assertion failed");

`endif

/* hw/rtl/sri_pkg.sv */
// Types and constants shared by the systematic resampler modules.
package sri_pkg;

    localparam int CMD_W    = 1;
    localparam int WEIGHT_W = 31;
    localparam int OFFSET_W = 32;
    localparam int SLOT_W   = 10;
    localparam int ANC_W    = 10;
    localparam int SUM_W    = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_QUOT,
        ST_FIX,
        ST_SETUP,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic write_edge;
        logic capture;
        logic multiply;
        logic quotient;
        logic correct;
        logic setup;
        logic search_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic search_done;
    } dp_status_t;

endpackage

/* hw/rtl/sri_ctrl.sv */
// Controller state machine of the systematic resampler.
module sri_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [sri_pkg::CMD_W-1:0]  cmd,
    output logic                       result_valid,
    input  logic                       result_ready,
    output sri_pkg::dp_cmd_t           dp_cmd,
    input  sri_pkg::dp_status_t        dp_status
);

    sri_pkg::state_t state_reg;
    sri_pkg::state_t state_next;
    logic            result_valid_reg;
    logic            result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sri_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        item_ready = 1'b0;
        case (state_reg)
            sri_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (cmd == sri_pkg::CMD_QUERY)
                    begin
                        dp_cmd.capture = 1'b1;
                        state_next     = sri_pkg::ST_MUL;
                    end
                    else
                    begin
                        dp_cmd.write_edge = 1'b1;
                    end
                end
            end
            sri_pkg::ST_MUL:
            begin
                dp_cmd.multiply = 1'b1;
                state_next      = sri_pkg::ST_QUOT;
            end
            sri_pkg::ST_QUOT:
            begin
                dp_cmd.quotient = 1'b1;
                state_next      = sri_pkg::ST_FIX;
            end
            sri_pkg::ST_FIX:
            begin
                dp_cmd.correct = 1'b1;
                state_next     = sri_pkg::ST_SETUP;
            end
            sri_pkg::ST_SETUP:
            begin
                dp_cmd.setup = 1'b1;
                state_next   = sri_pkg::ST_SEARCH;
            end
            sri_pkg::ST_SEARCH:
            begin
                dp_cmd.search_step = 1'b1;
                if (dp_status.search_done)
                begin
                    state_next = sri_pkg::ST_EMIT;
                end
            end
            sri_pkg::ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    dp_cmd.emit = 1'b1;
                    state_next  = sri_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sri_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

/* hw/rtl/sri_datapath.sv */
// Datapath of the systematic resampler: edge memory, offset scaling and binary search.
module sri_datapath #(
    parameter int PARTICLES = 1024,
    parameter int FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sri_pkg::dp_cmd_t              dp_cmd,
    output sri_pkg::dp_status_t           dp_status,
    input  logic [sri_pkg::WEIGHT_W-1:0]  weight,
    input  logic [sri_pkg::OFFSET_W-1:0]  offset,
    input  logic [sri_pkg::SLOT_W-1:0]    slot,
    output logic [sri_pkg::ANC_W-1:0]     ancestor
);

    localparam int AW    = $clog2(PARTICLES);
    localparam int IW    = AW + 2;
    localparam int EW    = FRAC_BITS + 1;
    localparam int SW    = FRAC_BITS + sri_pkg::SLOT_W;
    localparam int UW    = SW + 1;
    localparam int SHIFT = FRAC_BITS + AW;
    localparam int RW    = FRAC_BITS + 1;
    localparam int PW    = FRAC_BITS + RW;

    localparam logic [63:0]          RECIP64 = (64'd1 << SHIFT) / 64'(PARTICLES);
    localparam logic [RW-1:0]        RECIP   = RECIP64[RW-1:0];
    localparam logic [63:0]          STEP64  = (64'd1 << FRAC_BITS) / 64'(PARTICLES);
    localparam logic [FRAC_BITS-1:0] STEP    = STEP64[FRAC_BITS-1:0];
    localparam logic [EW-1:0]        ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] MAG_MAX = {FRAC_BITS{1'b1}};
    localparam logic [FRAC_BITS-1:0] P_FX    = FRAC_BITS'(PARTICLES);
    localparam logic [AW:0]          P_CNT   = (AW + 1)'(PARTICLES);
    localparam logic [AW-1:0]        LAST    = AW'(PARTICLES - 1);
    localparam logic [AW-1:0]        MID0    = AW'((PARTICLES - 1) / 2);
    localparam logic signed [IW-1:0] TOP0    = IW'(PARTICLES - 1);
    localparam logic signed [IW-1:0] ONE_I   = IW'(1);

    logic [EW-1:0] edge_mem [PARTICLES];

    logic [sri_pkg::SUM_W-1:0] sum_reg;
    logic [AW-1:0]             pos_reg;

    logic [FRAC_BITS-1:0]      mag_reg;
    logic [sri_pkg::SLOT_W-1:0] slot_reg;
    logic [PW-1:0]             prod_reg;
    logic [SW-1:0]             slotstep_reg;
    logic [FRAC_BITS-1:0]      q0_reg;
    logic [FRAC_BITS-1:0]      qp_reg;
    logic [FRAC_BITS-1:0]      start_reg;
    logic [UW-1:0]             u_reg;
    logic signed [IW-1:0]      bottom_reg;
    logic signed [IW-1:0]      top_reg;
    logic [AW-1:0]             mid_reg;
    logic [EW-1:0]             rd_hi_reg;
    logic [EW-1:0]             rd_lo_reg;
    logic [AW-1:0]             result_reg;
    logic [sri_pkg::ANC_W-1:0] anc_reg;

    logic [sri_pkg::SUM_W:0]   sum_ext;
    logic [sri_pkg::SUM_W-1:0] sum_sat;
    logic [EW-1:0]             edge_val;
    logic [AW:0]               pos_inc;
    logic                      frame_end;

    logic [32:0]               off_ext;
    logic [32:0]               abs_off;
    logic [FRAC_BITS-1:0]      mag_clip;

    logic [FRAC_BITS-1:0]      q0_c;
    logic [FRAC_BITS-1:0]      rem_c;

    logic [UW-1:0]             hi_u;
    logic [UW-1:0]             lo_u;
    logic                      gt;
    logic                      lt;
    logic                      match;
    logic                      over;
    logic signed [IW-1:0]      mid_s;
    logic signed [IW-1:0]      bottom_n;
    logic signed [IW-1:0]      top_n;
    logic [IW:0]               bt_sum;
    logic [AW-1:0]             mid_n;
    logic [AW-1:0]             rd_addr;
    logic [AW-1:0]             rd_addr_lo;
    logic [AW-1:0]             res_c;
    logic [11:0]               res_wide;

    // Load path: saturating running sum, edges clipped to 1.0.
    assign sum_ext   = {1'b0, sum_reg} + {2'b00, weight};
    assign sum_sat   = sum_ext[sri_pkg::SUM_W] ? '1 : sum_ext[sri_pkg::SUM_W-1:0];
    assign edge_val  = (sum_sat > 32'(ONE_FX)) ? ONE_FX : sum_sat[EW-1:0];
    assign pos_inc   = {1'b0, pos_reg} + (AW + 1)'(1);
    assign frame_end = (pos_inc >= P_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            pos_reg <= '0;
        end
        else if (dp_cmd.write_edge)
        begin
            if (frame_end)
            begin
                sum_reg <= '0;
                pos_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_sat;
                pos_reg <= pos_inc[AW-1:0];
            end
        end
    end

    // Offset magnitude, clipped just below 1.0.
    assign off_ext  = {offset[sri_pkg::OFFSET_W-1], offset};
    assign abs_off  = offset[sri_pkg::OFFSET_W-1] ? (33'd0 - off_ext) : off_ext;
    assign mag_clip = (abs_off > 33'(MAG_MAX)) ? MAG_MAX : abs_off[FRAC_BITS-1:0];

    // The reciprocal product gives the quotient or one less; the remainder fixes it.
    assign q0_c  = FRAC_BITS'(prod_reg >> SHIFT);
    assign rem_c = mag_reg - qp_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            mag_reg  <= mag_clip;
            slot_reg <= slot;
        end
        if (dp_cmd.multiply)
        begin
            prod_reg     <= PW'(mag_reg) * PW'(RECIP);
            slotstep_reg <= SW'(slot_reg) * SW'(STEP);
        end
        if (dp_cmd.quotient)
        begin
            q0_reg <= q0_c;
            qp_reg <= q0_c * P_FX;
        end
        if (dp_cmd.correct)
        begin
            start_reg <= q0_reg + ((rem_c >= P_FX) ? FRAC_BITS'(1) : FRAC_BITS'(0));
        end
    end

    // Binary search step on the edges read for mid_reg.
    assign hi_u  = (mid_reg == '0) ? '0 : UW'(rd_hi_reg);
    assign lo_u  = (mid_reg == '0) ? UW'(start_reg)
                 : ((mid_reg == AW'(1)) ? '0 : UW'(rd_lo_reg));
    assign gt    = (u_reg > hi_u);
    assign lt    = (u_reg < lo_u);
    assign match = !gt && !lt;

    assign mid_s    = {2'b00, mid_reg};
    assign bottom_n = gt ? (mid_s + ONE_I) : bottom_reg;
    assign top_n    = (!gt && lt) ? (mid_s - ONE_I) : top_reg;
    assign over     = (bottom_n > top_n);
    assign bt_sum   = {bottom_n[IW-1], bottom_n} + {top_n[IW-1], top_n};
    assign mid_n    = bt_sum[AW:1];

    assign res_c    = (match && (mid_reg != '0)) ? (mid_reg - AW'(1)) : LAST;
    assign res_wide = 12'(result_reg);

    assign dp_status.search_done = match || over;

    assign rd_addr    = dp_cmd.setup ? MID0 : mid_n;
    assign rd_addr_lo = rd_addr - AW'(1);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.setup)
        begin
            u_reg      <= UW'(start_reg) + UW'(slotstep_reg);
            bottom_reg <= '0;
            top_reg    <= TOP0;
            mid_reg    <= MID0;
        end
        else if (dp_cmd.search_step)
        begin
            bottom_reg <= bottom_n;
            top_reg    <= top_n;
            mid_reg    <= mid_n;
            if (match || over)
            begin
                result_reg <= res_c;
            end
        end
        if (dp_cmd.emit)
        begin
            anc_reg <= res_wide[sri_pkg::ANC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.write_edge && !frame_end)
        begin
            edge_mem[pos_inc[AW-1:0]] <= edge_val;
        end
        rd_hi_reg <= edge_mem[rd_addr];
        rd_lo_reg <= edge_mem[rd_addr_lo];
    end

    assign ancestor = anc_reg;

endmodule

/* hw/rtl/systematic_resample_index.sv */
// Systematic resampler top level: ancestor index lookup over cumulative weights.
// A load word (cmd 0) adds its weight to a saturating running sum and stores the sum,
// clipped to 1.0, as the next cumulative edge (a frame's last word only restarts the
// sum); the block is ready again at once, so loads stream at one word per cycle. A
// query word (cmd 1) scales the offset by 1/PARTICLES through a reciprocal multiply
// with a correction step, adds the slot's share, and then runs a binary search that
// reads adjacent edges through separate read ports. One query is worked on at a time,
// and a finished result waits in the output register while the next word is taken; a
// query that ends while the last result still waits holds until that result is taken.
// The edge memory needs no clearing pass after reset; query only edges already loaded.
module systematic_resample_index #(
    parameter int PARTICLES = 1024,
    parameter int FRAC_BITS = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [sri_pkg::CMD_W-1:0]     cmd,
    input  logic [sri_pkg::WEIGHT_W-1:0]  weight,
    input  logic [sri_pkg::OFFSET_W-1:0]  offset,
    input  logic [sri_pkg::SLOT_W-1:0]    slot,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [sri_pkg::ANC_W-1:0]     ancestor
);

    sri_pkg::dp_cmd_t    dp_cmd;
    sri_pkg::dp_status_t dp_status;

    sri_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status)
    );

    sri_datapath #(
        .PARTICLES (PARTICLES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .weight    (weight),
        .offset    (offset),
        .slot      (slot),
        .ancestor  (ancestor)
    );

endmodule

/* hw/rtl/sri_checker.sv */
// Port-level assertion checker for the systematic resampler, bound to the top level.
`include "systematic_resample_index_assert.svh"

module sri_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic [sri_pkg::CMD_W-1:0]     cmd,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [sri_pkg::ANC_W-1:0]     ancestor
);

    // A stalled result word keeps its value.
    `SRI_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(ancestor))

    // A load word completes at once, so the block is ready again in the cycle after it.
    `SRI_ASSERT_NEXT(a_load_one_cycle, item_valid && item_ready && (cmd == sri_pkg::CMD_LOAD), item_ready)

    // A query closes the input side once it is taken.
    `SRI_ASSERT_NEXT(a_query_busy, item_valid && item_ready && (cmd == sri_pkg::CMD_QUERY), !item_ready)

    // A new result only appears at the end of a query, never from the ready state.
    `SRI_ASSERT_SAME(a_result_from_query, $rose(result_valid), !$past(item_ready))

endmodule

bind systematic_resample_index sri_checker u_sri_checker (.*);
